FILE: rtl/core/stable_priority_queue_defines.svh
// ---------------------------------------------------------------------------
// Stable priority queue assertion macros
// Shared helpers for the concurrent checks on the queue's stream ports.
// ---------------------------------------------------------------------------
`ifndef STABLE_PRIORITY_QUEUE_DEFINES_SVH
`define STABLE_PRIORITY_QUEUE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SPQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("stable priority queue: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define SPQ_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("stable priority queue: next-cycle check failed");

`endif

FILE: rtl/core/spq_pkg.sv
// ---------------------------------------------------------------------------
// Stable priority queue package
// Shared constants, status codes and the control group sent to the cells.
// ---------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

    // Default sizes of the queue.
    localparam int DEF_CAPACITY      = 16;
    localparam int DEF_PRIORITY_BITS = 16;
    localparam int DEF_PAYLOAD_BITS  = 32;

    // Fixed widths of the result fields.
    localparam int OCC_BITS    = 5;
    localparam int STATUS_BITS = 2;

    // Request kinds carried on the input tuser.
    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    // Result status codes.
    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // Operation broadcast to every cell in a cycle.
    typedef struct packed {
        logic enq;
        logic deq;
    } cell_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/core/spq_cell.sv
// ---------------------------------------------------------------------------
// Stable priority queue cell
// One slot of the sorted chain: holds, takes the new entry, or shifts.
// ---------------------------------------------------------------------------
`default_nettype none

module spq_cell
    import spq_pkg::*;
#(
    parameter int PRIORITY_BITS = DEF_PRIORITY_BITS,
    parameter int PAYLOAD_BITS  = DEF_PAYLOAD_BITS,
    parameter int CNT_W         = 5,
    parameter int IDX           = 0
)
(
    input  wire logic                            clk,
    input  wire cell_ctrl_t                      ctrl,
    input  wire logic [CNT_W-1:0]                count,
    input  wire logic signed [PRIORITY_BITS-1:0] new_prio,
    input  wire logic [PAYLOAD_BITS-1:0]         new_payload,
    input  wire logic                            prev_keep,
    input  wire logic signed [PRIORITY_BITS-1:0] prev_prio,
    input  wire logic [PAYLOAD_BITS-1:0]         prev_payload,
    input  wire logic signed [PRIORITY_BITS-1:0] next_prio,
    input  wire logic [PAYLOAD_BITS-1:0]         next_payload,
    output logic                                 keep,
    output logic signed [PRIORITY_BITS-1:0]      prio,
    output logic [PAYLOAD_BITS-1:0]              payload
);

    logic signed [PRIORITY_BITS-1:0] prio_reg;
    logic signed [PRIORITY_BITS-1:0] prio_next;
    logic [PAYLOAD_BITS-1:0]         payload_reg;
    logic [PAYLOAD_BITS-1:0]         payload_next;
    logic                            occupied;

    // The slot holds a live entry when it lies below the fill count.
    assign occupied = (count > CNT_W'(IDX));

    // An entry of greater or equal priority stays ahead of the new one.
    assign keep = occupied && (prio_reg >= new_prio);

    // Choose the slot's next contents.
    always_comb
    begin
        prio_next    = prio_reg;
        payload_next = payload_reg;
        if (ctrl.enq && !keep)
        begin
            if (prev_keep)
            begin
                prio_next    = new_prio;
                payload_next = new_payload;
            end
            else
            begin
                prio_next    = prev_prio;
                payload_next = prev_payload;
            end
        end
        else if (ctrl.deq)
        begin
            prio_next    = next_prio;
            payload_next = next_payload;
        end
    end

    // Entry storage; contents are meaningful only below the fill count.
    always_ff @(posedge clk)
    begin
        prio_reg    <= prio_next;
        payload_reg <= payload_next;
    end

    assign prio    = prio_reg;
    assign payload = payload_reg;

endmodule

`default_nettype wire

FILE: rtl/core/stable_priority_queue.sv
// ---------------------------------------------------------------------------
// Stable priority queue
// Bounded sorted queue built as a chain of compare-and-shift cells.
// ---------------------------------------------------------------------------
// For each request (enqueue or dequeue, chosen by s_tuser),
// every cell compares its stored priority with the incoming one and holds,
// loads the new entry or shifts in its neighbour's entry in the same edge,
// so a new request is taken every cycle as long as the result register is
// free or being drained. One result per request is offered the next cycle.
// Equal priorities leave in arrival order; an enqueue into a full queue is
// dropped with status full, a dequeue from an empty queue reports status
// empty. Occupancy is reported modulo 32.
`default_nettype none

module stable_priority_queue
    import spq_pkg::*;
#(
    parameter int CAPACITY      = DEF_CAPACITY,
    parameter int PRIORITY_BITS = DEF_PRIORITY_BITS,
    parameter int PAYLOAD_BITS  = DEF_PAYLOAD_BITS,
    localparam int S_TDATA_W    = ((PRIORITY_BITS + PAYLOAD_BITS + 7) / 8) * 8,
    localparam int M_TDATA_W    = ((PRIORITY_BITS + PAYLOAD_BITS + OCC_BITS + 7) / 8) * 8
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // fields from bit 0: priority_in, payload_in, zero fill
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    // fields from bit 0: opcode
    input  wire logic                 s_tuser,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // fields from bit 0: priority_out, payload_out, occupancy, zero fill
    output logic [M_TDATA_W-1:0]      m_tdata,
    // fields from bit 0: status
    output logic [STATUS_BITS-1:0]    m_tuser
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic                            accept;
    cell_ctrl_t                      ctrl;
    logic signed [PRIORITY_BITS-1:0] new_prio;
    logic [PAYLOAD_BITS-1:0]         new_payload;
    logic                            is_full;
    logic                            is_empty;
    logic [CNT_W-1:0]                count_reg;
    logic [CNT_W-1:0]                count_next;
    logic                            m_tvalid_reg;
    logic                            m_tvalid_next;
    logic [M_TDATA_W-1:0]            m_tdata_reg;
    logic [M_TDATA_W-1:0]            m_tdata_next;
    logic [STATUS_BITS-1:0]          m_tuser_reg;
    logic [STATUS_BITS-1:0]          m_tuser_next;
    logic signed [PRIORITY_BITS-1:0] prio_out;
    logic [PAYLOAD_BITS-1:0]         payload_out;
    status_t                         status;

    logic signed [PRIORITY_BITS-1:0] cell_prio [CAPACITY];
    logic [PAYLOAD_BITS-1:0]         cell_payload [CAPACITY];
    logic                            keep_chain [CAPACITY+1];

    // Request handshake: the result register is free or drains this cycle.
    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign new_prio    = s_tdata[PRIORITY_BITS-1:0];
    assign new_payload = s_tdata[PRIORITY_BITS+PAYLOAD_BITS-1:PRIORITY_BITS];

    assign is_full  = (count_reg == CNT_W'(CAPACITY));
    assign is_empty = (count_reg == '0);

    // Operation seen by the cells; rejected requests leave them untouched.
    assign ctrl.enq = accept && (s_tuser == OP_ENQ) && !is_full;
    assign ctrl.deq = accept && (s_tuser == OP_DEQ) && !is_empty;

    // The slot ahead of the front counts as keeping its place.
    assign keep_chain[0] = 1'b1;

    // Chain of cells, slot 0 at the front.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic signed [PRIORITY_BITS-1:0] prev_prio;
        logic [PAYLOAD_BITS-1:0]         prev_payload;
        logic signed [PRIORITY_BITS-1:0] next_prio;
        logic [PAYLOAD_BITS-1:0]         next_payload;

        if (i == 0)
        begin : g_head
            assign prev_prio    = new_prio;
            assign prev_payload = new_payload;
        end
        else
        begin : g_body
            assign prev_prio    = cell_prio[i-1];
            assign prev_payload = cell_payload[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_tail
            assign next_prio    = cell_prio[i];
            assign next_payload = cell_payload[i];
        end
        else
        begin : g_link
            assign next_prio    = cell_prio[i+1];
            assign next_payload = cell_payload[i+1];
        end

        spq_cell #(
            .PRIORITY_BITS (PRIORITY_BITS),
            .PAYLOAD_BITS  (PAYLOAD_BITS),
            .CNT_W         (CNT_W),
            .IDX           (i)
        ) u_cell (
            .clk          (clk),
            .ctrl         (ctrl),
            .count        (count_reg),
            .new_prio     (new_prio),
            .new_payload  (new_payload),
            .prev_keep    (keep_chain[i]),
            .prev_prio    (prev_prio),
            .prev_payload (prev_payload),
            .next_prio    (next_prio),
            .next_payload (next_payload),
            .keep         (keep_chain[i+1]),
            .prio         (cell_prio[i]),
            .payload      (cell_payload[i])
        );
    end

    // Fill count and result of the current request.
    always_comb
    begin
        count_next  = count_reg;
        status      = ST_OK;
        prio_out    = '0;
        payload_out = '0;
        if (ctrl.enq)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (ctrl.deq)
        begin
            count_next  = count_reg - CNT_W'(1);
            prio_out    = cell_prio[0];
            payload_out = cell_payload[0];
        end
        else if (s_tuser == OP_ENQ)
        begin
            status = ST_FULL;
        end
        else
        begin
            status = ST_EMPTY;
        end
    end

    // Result register loads on every accepted request.
    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        if (accept)
        begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = M_TDATA_W'({OCC_BITS'(count_next), payload_out, prio_out});
            m_tuser_next  = status;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg <= count_next;
            end
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

`default_nettype wire

FILE: rtl/core/spq_checker.sv
// ---------------------------------------------------------------------------
// Stable priority queue checker
// Port-level checks on the result stream, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "stable_priority_queue_defines.svh"

module spq_checker
    import spq_pkg::*;
#(
    parameter int CAPACITY      = DEF_CAPACITY,
    parameter int PRIORITY_BITS = DEF_PRIORITY_BITS,
    parameter int PAYLOAD_BITS  = DEF_PAYLOAD_BITS,
    localparam int S_TDATA_W    = ((PRIORITY_BITS + PAYLOAD_BITS + 7) / 8) * 8,
    localparam int M_TDATA_W    = ((PRIORITY_BITS + PAYLOAD_BITS + OCC_BITS + 7) / 8) * 8
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_tvalid,
    input  wire logic                   s_tready,
    // fields from bit 0: priority_in, payload_in, zero fill
    input  wire logic [S_TDATA_W-1:0]   s_tdata,
    // fields from bit 0: opcode
    input  wire logic                   s_tuser,
    input  wire logic                   m_tvalid,
    input  wire logic                   m_tready,
    // fields from bit 0: priority_out, payload_out, occupancy, zero fill
    input  wire logic [M_TDATA_W-1:0]   m_tdata,
    // fields from bit 0: status
    input  wire logic [STATUS_BITS-1:0] m_tuser
);

    localparam int ENTRY_BITS = PRIORITY_BITS + PAYLOAD_BITS;

    logic [OCC_BITS-1:0]   occ;
    logic [ENTRY_BITS-1:0] entry;
    logic                  is_empty_res;
    logic                  is_full_res;
    logic                  unused_in;

    assign occ          = m_tdata[ENTRY_BITS+OCC_BITS-1:ENTRY_BITS];
    assign entry        = m_tdata[ENTRY_BITS-1:0];
    assign is_empty_res = m_tvalid && (m_tuser == ST_EMPTY);
    assign is_full_res  = m_tvalid && (m_tuser == ST_FULL);
    assign unused_in    = s_tvalid ^ s_tready ^ s_tuser ^ (^s_tdata);

    // A result waiting on the consumer stays offered.
    `SPQ_ASSERT_NXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid)

    // A rejected dequeue returns no entry and an empty queue.
    `SPQ_ASSERT_IMP(a_empty_res, clk, rst_n, is_empty_res, (entry == '0) && (occ == '0))

    // A rejected enqueue returns no entry and reports the queue at capacity.
    `SPQ_ASSERT_IMP(a_full_res, clk, rst_n, is_full_res,
                    (entry == '0) && (occ == OCC_BITS'(CAPACITY)))

    // Below 32 slots, no result reports more entries than the queue can hold.
    `SPQ_ASSERT_IMP(a_occ_range, clk, rst_n, m_tvalid && (CAPACITY < 32),
                    occ <= OCC_BITS'(CAPACITY))

endmodule

bind stable_priority_queue spq_checker #(
    .CAPACITY      (CAPACITY),
    .PRIORITY_BITS (PRIORITY_BITS),
    .PAYLOAD_BITS  (PAYLOAD_BITS)
) u_spq_checker (.*);

`default_nettype wire
